>>> rtl/fsc_pkg.sv
// ============================================================================
// fsc_pkg
// Shared types, constants and helper functions for the Feistel block cipher
// whose round function is SHA-256 over the right half of the block.
// ============================================================================
package fsc_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int WORDS       = BLOCK_BYTES / 8;
  localparam int HALF_WORDS  = WORDS / 2;

  localparam logic [3:0] ROUND_COUNT_RESET = 4'd5;

  typedef struct packed {
    logic        mode;
    logic [63:0] data_word;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_word;
    logic        result_last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the input word at the load index
    logic zero_fill;   // clear all words above the load index
    logic swap;        // exchange the two halves
    logic hash_init;   // build the message block and load the IV
    logic hash_step;   // one compression step
    logic round_end;   // fold the digest into the halves
    logic emit_shift;  // move the block down by one word
  } ctrl_t;

  typedef logic [7:0][31:0] sha_state_t;

  localparam sha_state_t SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/feistel_sha256_block_cipher_top.sv
// ============================================================================
// feistel_sha256_block_cipher_top
// Feistel block cipher with SHA-256 of the right half as round function.
// ============================================================================
// Usage:
// Input words are taken at a rising edge where start is high and busy is low.
// Eight 64-bit words make one 64-byte block; last_word closes a block early,
// and the missing words are zero. mode is sampled on the first word.
// After the closing word busy rises. A swap state handles the optional half
// swap, then each round runs a setup step for the message block, 64
// compression steps and a step that folds the digest into the halves. A
// second swap state follows, then the eight result words leave back to
// back, each marked by result_valid, with result_last on the eighth.
// The compression unit, one step per cycle, sets the time per block.
// The receiver cannot stall; results must be taken as they appear.
// Reset clears the controller and sets round_count to five; block contents
// are undefined until loaded. round_count is written through cfg_we.
// ============================================================================
module feistel_sha256_block_cipher_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  fsc_pkg::in_word_t  in_word,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  output logic               result_valid,
  output fsc_pkg::out_word_t result
);

  fsc_pkg::ctrl_t ctrl;
  logic [3:0]     round_count;
  logic [2:0]     load_index;
  logic [5:0]     step;
  logic           emit_last;
  logic [63:0]    head_word;

  // Round count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= fsc_pkg::ROUND_COUNT_RESET;
    end else if (cfg_we) begin
      round_count <= cfg_data;
    end
  end

  fsc_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (in_word.mode),
    .last_word  (in_word.last_word),
    .round_count(round_count),
    .busy       (busy),
    .ctrl       (ctrl),
    .load_index (load_index),
    .step       (step),
    .emit_valid (result_valid),
    .emit_last  (emit_last)
  );

  fsc_datapath u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .load_index(load_index),
    .step      (step),
    .data_word (in_word.data_word),
    .head_word (head_word)
  );

  assign result.result_word = head_word;
  assign result.result_last = emit_last;

endmodule

>>> rtl/fsc_datapath.sv
// ============================================================================
// fsc_datapath
// Block storage, SHA-256 compression unit (one step per cycle) and the
// Feistel mixing of the digest into the halves.
// ============================================================================
module fsc_datapath (
  input  logic                 clk,
  input  fsc_pkg::ctrl_t       ctrl,
  input  logic [2:0]           load_index,
  input  logic [5:0]           step,
  input  logic [63:0]          data_word,
  output logic [63:0]          head_word
);

  logic [fsc_pkg::WORDS-1:0][63:0] blk;
  fsc_pkg::sha_state_t             h;
  logic [15:0][31:0]               w;

  logic [31:0] wt, g0, g1, s0, s1, ch, mj, t1, t2;
  logic [fsc_pkg::HALF_WORDS-1:0][63:0] digest;

  // Message word for this step: schedule head, extended after step 15.
  always_comb begin
    g0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    g1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    wt = (step < 6'd16) ? w[0] : (w[0] + g0 + w[9] + g1);
    s1 = {h[4][5:0], h[4][31:6]} ^ {h[4][10:0], h[4][31:11]} ^ {h[4][24:0], h[4][31:25]};
    ch = (h[4] & h[5]) ^ (~h[4] & h[6]);
    t1 = h[7] + s1 + ch + fsc_pkg::sha_k(step) + wt;
    s0 = {h[0][1:0], h[0][31:2]} ^ {h[0][12:0], h[0][31:13]} ^ {h[0][21:0], h[0][31:22]};
    mj = (h[0] & h[1]) ^ (h[0] & h[2]) ^ (h[1] & h[2]);
    t2 = s0 + mj;
  end

  // Final digest: working state plus IV.
  always_comb begin
    for (int i = 0; i < fsc_pkg::HALF_WORDS; i++) begin
      digest[i] = {h[2*i] + fsc_pkg::SHA_IV[2*i], h[2*i+1] + fsc_pkg::SHA_IV[2*i+1]};
    end
  end

  // Block storage.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      blk[load_index] <= data_word;
    end
    if (ctrl.zero_fill) begin
      for (int i = 0; i < fsc_pkg::WORDS; i++) begin
        if (3'(i) > load_index) blk[i] <= '0;
      end
    end
    if (ctrl.swap) begin
      for (int i = 0; i < fsc_pkg::HALF_WORDS; i++) begin
        blk[i] <= blk[i+fsc_pkg::HALF_WORDS];
        blk[i+fsc_pkg::HALF_WORDS] <= blk[i];
      end
    end
    if (ctrl.round_end) begin
      for (int i = 0; i < fsc_pkg::HALF_WORDS; i++) begin
        blk[i] <= blk[i+fsc_pkg::HALF_WORDS];
        blk[i+fsc_pkg::HALF_WORDS] <= digest[i] ^ blk[i];
      end
    end
    if (ctrl.emit_shift) begin
      for (int i = 0; i < fsc_pkg::WORDS-1; i++) blk[i] <= blk[i+1];
    end
  end

  // Hash state and a 16-entry schedule that rotates one word each step.
  always_ff @(posedge clk) begin
    if (ctrl.hash_init) begin
      h <= fsc_pkg::SHA_IV;
      for (int i = 0; i < fsc_pkg::HALF_WORDS; i++) begin
        w[2*i]   <= blk[i+fsc_pkg::HALF_WORDS][63:32];
        w[2*i+1] <= blk[i+fsc_pkg::HALF_WORDS][31:0];
      end
      w[8] <= 32'h80000000;
      for (int i = 9; i < 15; i++) w[i] <= '0;
      w[15] <= 32'd256;
    end else if (ctrl.hash_step) begin
      h <= {h[6], h[5], h[4], h[3] + t1, h[2], h[1], h[0], t1 + t2};
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
    end
  end

  assign head_word = blk[0];

endmodule

>>> rtl/fsc_controller.sv
// ============================================================================
// fsc_controller
// State machine that sequences loading, the Feistel rounds and the emission
// of the eight result words.
// ============================================================================
module fsc_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           mode,
  input  logic           last_word,
  input  logic [3:0]     round_count,
  output logic           busy,
  output fsc_pkg::ctrl_t ctrl,
  output logic [2:0]     load_index,
  output logic [5:0]     step,
  output logic           emit_valid,
  output logic           emit_last
);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_SWAP1 = 7'b0000010,
    S_INIT  = 7'b0000100,
    S_HASH  = 7'b0001000,
    S_FOLD  = 7'b0010000,
    S_SWAP2 = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic        block_mode;
  logic [3:0]  feistel_round;
  logic [2:0]  emit_count;
  logic        accept, done;

  assign accept = start && !busy;
  assign done   = accept && (load_index == 3'd7 || last_word);
  assign busy   = (state != S_LOAD);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (done) state_next = S_SWAP1;
      end
      S_SWAP1: begin
        state_next = (round_count == 4'd0) ? S_SWAP2 : S_INIT;
      end
      S_INIT: begin
        state_next = S_HASH;
      end
      S_HASH: begin
        if (step == 6'd63) state_next = S_FOLD;
      end
      S_FOLD: begin
        state_next = (feistel_round == 4'd0) ? S_SWAP2 : S_INIT;
      end
      S_SWAP2: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_count == 3'd7) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Datapath commands; the digest is folded in once the last step has landed.
  always_comb begin
    ctrl            = '0;
    ctrl.load       = accept;
    ctrl.zero_fill  = done;
    ctrl.swap       = (state == S_SWAP1 || state == S_SWAP2) && block_mode;
    ctrl.hash_init  = (state == S_INIT);
    ctrl.hash_step  = (state == S_HASH);
    ctrl.round_end  = (state == S_FOLD);
    ctrl.emit_shift = (state == S_EMIT);
  end

  assign emit_valid = (state == S_EMIT);
  assign emit_last  = (state == S_EMIT) && (emit_count == 3'd7);

  // Control registers; feistel_round counts the rounds still to go after the current one.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      load_index    <= '0;
      block_mode    <= 1'b0;
      feistel_round <= '0;
      step          <= '0;
      emit_count    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (load_index == 3'd0) block_mode <= mode;
        load_index <= done ? 3'd0 : load_index + 3'd1;
      end
      if (state == S_SWAP1) feistel_round <= round_count - 4'd1;
      if (state == S_HASH) step <= step + 6'd1;
      if (state == S_FOLD && feistel_round != 4'd0) feistel_round <= feistel_round - 4'd1;
      if (state == S_EMIT) emit_count <= emit_count + 3'd1;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !ctrl.load)
    else $error("word loaded while busy");
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_HASH) |-> (step == 6'd0))
    else $error("hash step counter not at zero outside hashing");
  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    emit_last |=> (state == S_LOAD))
    else $error("did not return to load after last word");
`endif

endmodule
